// File: rtl/core/bfda_pkg.sv
// Constants and helper functions shared by the fixed-point to decimal ASCII formatter.
package bfda_pkg;

    // Largest input value that can be displayed (999.98 after rounding).
    localparam logic [31:0] ValueLimit = 32'd63999;

    // Six-bit ASCII codes used on the character outputs.
    localparam logic [5:0] CharBlank = 6'd32;
    localparam logic [5:0] CharStar  = 6'd42;
    localparam logic [5:0] CharPoint = 6'd46;
    localparam logic [5:0] CharZero  = 6'd48;

    // Scale to hundredths: (value * 100 + 32) >> 6.
    localparam logic [22:0] Scale100  = 23'd100;
    localparam logic [22:0] RoundHalf = 23'd32;

    // Reciprocal constants for division by a constant.
    // h / 100 for h below 100000: (h * 167773) >> 24.
    localparam logic [34:0] Recip100Wide = 35'd167773;
    // q / 100 for q below 1024: (q * 41) >> 12.
    localparam logic [15:0] Recip100Narrow = 16'd41;
    // r / 10 for r below 128: (r * 205) >> 11.
    localparam logic [14:0] Recip10 = 15'd205;

    typedef logic [3:0] digit_t;
    typedef logic [5:0] char_t;

    // ASCII code of a decimal digit.
    function automatic char_t digit_char(input digit_t d);
        digit_char = CharZero + {2'b00, d};
    endfunction

endpackage

// File: rtl/core/binary_fixed_to_decimal_ascii_top.sv
// Pipelined converter from unsigned 1/64 fixed point to a six-character DDD.DD string.
//
//  Channel | Signals                                     | Direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_stall, value[31:0]             | in
//  output  | out_valid, out_stall, char0..char5, overflow| out
//
// One transfer is taken every cycle unless an output stall has filled every stage.
// The depth is set by the constant-reciprocal multiplies, each followed by a register.
// Every stage has its own valid bit and advances when the stage after it is empty or moving,
// so bubbles close up and a stall on the output holds all data without loss.
// Reset (rst_n low) clears the valid bits only.
module binary_fixed_to_decimal_ascii_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  char0,
    output logic [5:0]  char1,
    output logic [5:0]  char2,
    output logic [5:0]  char3,
    output logic [5:0]  char4,
    output logic [5:0]  char5,
    output logic        overflow
);

    // Stage valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;

    // Stage enables.
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: hundredths value and range check.
    logic [16:0] s1_h_reg;
    logic        s1_ovf_reg;
    logic [22:0] s1_sum;

    // Stage 2: h / 100.
    logic [16:0] s2_h_reg;
    logic [9:0]  s2_q_reg;
    logic        s2_ovf_reg;
    logic [34:0] s2_prod;

    // Stage 3: low two digits and ten-thousands digit.
    logic [6:0]           s3_r0_reg;
    logic [9:0]           s3_q_reg;
    bfda_pkg::digit_t     s3_d4_reg;
    logic                 s3_ovf_reg;
    logic [15:0]          s3_prod;
    logic [16:0]          s3_r0_wide;

    // Stage 4: middle two digits and tenths digit.
    logic [6:0]           s4_rq_reg;
    logic [6:0]           s4_r0_reg;
    bfda_pkg::digit_t     s4_d1_reg;
    bfda_pkg::digit_t     s4_d4_reg;
    logic                 s4_ovf_reg;
    logic [14:0]          s4_prod;
    logic [9:0]           s4_rq_wide;

    // Stage 5: thousands and hundredths digits.
    logic [6:0]           s5_rq_reg;
    bfda_pkg::digit_t     s5_d3_reg;
    bfda_pkg::digit_t     s5_d1_reg;
    bfda_pkg::digit_t     s5_d0_reg;
    bfda_pkg::digit_t     s5_d4_reg;
    logic                 s5_ovf_reg;
    logic [14:0]          s5_prod;
    logic [6:0]           s5_d0_wide;

    // Output stage.
    bfda_pkg::char_t      char0_reg, char1_reg, char2_reg, char3_reg, char4_reg, char5_reg;
    logic                 ovf_reg;
    logic [6:0]           s6_d2_wide;
    bfda_pkg::digit_t     s6_d2;
    bfda_pkg::char_t      char0_next, char1_next, char2_next, char4_next, char5_next;

    assign en6 = !out_valid_reg || !out_stall;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en6)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Stage 1 logic. The low 16 bits cover every value in range; out-of-range
    // values only carry the overflow flag forward.
    assign s1_sum = {7'b0, value[15:0]} * bfda_pkg::Scale100 + bfda_pkg::RoundHalf;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_h_reg   <= s1_sum[22:6];
            s1_ovf_reg <= value > bfda_pkg::ValueLimit;
        end
    end

    // Stage 2 logic.
    assign s2_prod = {18'b0, s1_h_reg} * bfda_pkg::Recip100Wide;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_h_reg   <= s1_h_reg;
            s2_q_reg   <= s2_prod[33:24];
            s2_ovf_reg <= s1_ovf_reg;
        end
    end

    // Stage 3 logic.
    assign s3_r0_wide = s2_h_reg - {1'b0, s2_q_reg, 6'b0} - {2'b0, s2_q_reg, 5'b0}
                        - {5'b0, s2_q_reg, 2'b0};
    assign s3_prod    = {6'b0, s2_q_reg} * bfda_pkg::Recip100Narrow;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_r0_reg  <= s3_r0_wide[6:0];
            s3_q_reg   <= s2_q_reg;
            s3_d4_reg  <= s3_prod[15:12];
            s3_ovf_reg <= s2_ovf_reg;
        end
    end

    // Stage 4 logic.
    assign s4_rq_wide = s3_q_reg - 10'(s3_d4_reg) * 10'd100;
    assign s4_prod    = {8'b0, s3_r0_reg} * bfda_pkg::Recip10;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_rq_reg  <= s4_rq_wide[6:0];
            s4_r0_reg  <= s3_r0_reg;
            s4_d1_reg  <= s4_prod[14:11];
            s4_d4_reg  <= s3_d4_reg;
            s4_ovf_reg <= s3_ovf_reg;
        end
    end

    // Stage 5 logic.
    assign s5_prod    = {8'b0, s4_rq_reg} * bfda_pkg::Recip10;
    assign s5_d0_wide = s4_r0_reg - 7'(s4_d1_reg * 7'd10);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_rq_reg  <= s4_rq_reg;
            s5_d3_reg  <= s5_prod[14:11];
            s5_d1_reg  <= s4_d1_reg;
            s5_d0_reg  <= s5_d0_wide[3:0];
            s5_d4_reg  <= s4_d4_reg;
            s5_ovf_reg <= s4_ovf_reg;
        end
    end

    // Output stage logic: last digit, blanking of leading zeros, stars on overflow.
    assign s6_d2_wide = s5_rq_reg - 7'(s5_d3_reg * 7'd10);
    assign s6_d2      = s6_d2_wide[3:0];

    always_comb
    begin
        if (s5_ovf_reg)
        begin
            char0_next = bfda_pkg::CharStar;
            char1_next = bfda_pkg::CharStar;
            char2_next = bfda_pkg::CharStar;
            char4_next = bfda_pkg::CharStar;
            char5_next = bfda_pkg::CharStar;
        end
        else
        begin
            char0_next = (s5_d4_reg != '0) ? bfda_pkg::digit_char(s5_d4_reg)
                                            : bfda_pkg::CharBlank;
            char1_next = (s5_d4_reg != '0 || s5_d3_reg != '0)
                         ? bfda_pkg::digit_char(s5_d3_reg) : bfda_pkg::CharBlank;
            char2_next = bfda_pkg::digit_char(s6_d2);
            char4_next = bfda_pkg::digit_char(s5_d1_reg);
            char5_next = bfda_pkg::digit_char(s5_d0_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            char0_reg <= char0_next;
            char1_reg <= char1_next;
            char2_reg <= char2_next;
            char3_reg <= bfda_pkg::CharPoint;
            char4_reg <= char4_next;
            char5_reg <= char5_next;
            ovf_reg   <= s5_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign char0     = char0_reg;
    assign char1     = char1_reg;
    assign char2     = char2_reg;
    assign char3     = char3_reg;
    assign char4     = char4_reg;
    assign char5     = char5_reg;
    assign overflow  = ovf_reg;

    // An empty output register means the whole pipeline can move.
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while output register is empty");

    // An overflow result shows stars; the check looks at char0, char2 and char5.
    a_overflow_stars: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            char0 == bfda_pkg::CharStar && char2 == bfda_pkg::CharStar &&
            char5 == bfda_pkg::CharStar)
        else $error("overflow result without stars");

    // A result in range always shows a real units digit.
    a_units_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |->
            char2 >= bfda_pkg::CharZero && char2 <= bfda_pkg::digit_char(4'd9))
        else $error("units digit out of range");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the fixed-point to decimal ASCII formatter.
module tb_top;

    localparam int CycleLimit   = 200000;
    localparam int PhaseItems   = 400;
    localparam int DrainCycles  = 12;

    typedef struct packed {
        bfda_pkg::char_t ch0;
        bfda_pkg::char_t ch1;
        bfda_pkg::char_t ch2;
        bfda_pkg::char_t ch3;
        bfda_pkg::char_t ch4;
        bfda_pkg::char_t ch5;
        logic            ovf;
    } decimal_text_t;

    class decimal_text_checker;
        decimal_text_t expected_text[$];
        int            error_count;

        function new();
            error_count = 0;
        endfunction

        // Hundredths rounded to nearest, then split into five decimal digits.
        function decimal_text_t format_hundredths(logic [31:0] v);
            decimal_text_t t;
            int unsigned   hund;
            int unsigned   dig[5];
            if (v > bfda_pkg::ValueLimit) begin
                t = '{bfda_pkg::CharStar, bfda_pkg::CharStar, bfda_pkg::CharStar,
                      bfda_pkg::CharPoint, bfda_pkg::CharStar, bfda_pkg::CharStar, 1'b1};
                return t;
            end
            hund   = (v * 100 + 32) >> 6;
            dig[4] = hund / 10000;
            dig[3] = (hund / 1000) % 10;
            dig[2] = (hund / 100) % 10;
            dig[1] = (hund / 10) % 10;
            dig[0] = hund % 10;
            t.ch0 = (dig[4] != 0) ? bfda_pkg::char_t'(bfda_pkg::CharZero + dig[4])
                                  : bfda_pkg::CharBlank;
            t.ch1 = (dig[4] != 0 || dig[3] != 0)
                    ? bfda_pkg::char_t'(bfda_pkg::CharZero + dig[3]) : bfda_pkg::CharBlank;
            t.ch2 = bfda_pkg::char_t'(bfda_pkg::CharZero + dig[2]);
            t.ch3 = bfda_pkg::CharPoint;
            t.ch4 = bfda_pkg::char_t'(bfda_pkg::CharZero + dig[1]);
            t.ch5 = bfda_pkg::char_t'(bfda_pkg::CharZero + dig[0]);
            t.ovf = 1'b0;
            return t;
        endfunction

        function void take_value(logic [31:0] v);
            expected_text.push_back(format_hundredths(v));
        endfunction

        function void compare_field(string name, logic [5:0] exp_v, logic [5:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_text(decimal_text_t act);
            decimal_text_t exp_t;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected output transfer, expected none, got %h", $time, act);
                error_count++;
                return;
            end
            exp_t = expected_text.pop_front();
            compare_field("char0", exp_t.ch0, act.ch0);
            compare_field("char1", exp_t.ch1, act.ch1);
            compare_field("char2", exp_t.ch2, act.ch2);
            compare_field("char3", exp_t.ch3, act.ch3);
            compare_field("char4", exp_t.ch4, act.ch4);
            compare_field("char5", exp_t.ch5, act.ch5);
            compare_field("overflow", {5'd0, exp_t.ovf}, {5'd0, act.ovf});
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    logic [31:0]     value     = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    bfda_pkg::char_t char0, char1, char2, char3, char4, char5;
    logic            overflow;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;

    decimal_text_checker checker_h = new();

    binary_fixed_to_decimal_ascii_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char0     (char0),
        .char1     (char1),
        .char2     (char2),
        .char3     (char3),
        .char4     (char4),
        .char5     (char5),
        .overflow  (overflow)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Both channels are sampled in one process, so an input transfer is always
    // recorded before a result at the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                checker_h.take_value(value);
            if (out_valid && !out_stall)
                checker_h.check_text('{char0, char1, char2, char3, char4, char5, overflow});
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Weighted toward the valid range, with blank-digit ranges and both sides
    // of the overflow threshold well covered.
    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return $urandom();
        else if (sel < 11)
            return 32'd64000 + $urandom_range(0, 40);
        else if (sel < 16)
            return 32'd63999 - $urandom_range(0, 40);
        else if (sel < 34)
            return $urandom_range(0, 639);
        else if (sel < 50)
            return $urandom_range(640, 6399);
        else
            return $urandom_range(0, 63999);
    endfunction

    int          idle_tab[4]  = '{0, 86, 0, 31};
    int          stall_tab[4] = '{0, 0, 86, 31};
    logic [31:0] directed[$]  = '{32'd0, 32'd1, 32'd31, 32'd32, 32'd63, 32'd64, 32'd639,
                                  32'd640, 32'd6399, 32'd6400, 32'd63998, 32'd63999,
                                  32'd64000, 32'd64001, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'h7FFF_FFFF, 32'd41573, 32'd12345};

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i]);

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = idle_tab[p];
            receiver_stall_pct = stall_tab[p];
            repeat (PhaseItems)
                send_value(pick_value());
        end
        in_valid <= 1'b0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (checker_h.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: files.f
rtl/core/bfda_pkg.sv
rtl/core/binary_fixed_to_decimal_ascii_top.sv
tb/sv/tb_top.sv
